// ----- rtl/lphi_pkg.sv -----
package lphi_pkg;

   localparam int DEF_MAX_TABLE_BITS = 10;
   localparam int KEY_W              = 64;
   localparam int POS_W              = 10;
   localparam int KEY_DEPTH          = 1 << POS_W;
   localparam int SLOT_W             = POS_W + 1;
   localparam int FUNC_W             = 2;
   localparam int STATUS_W           = 2;
   localparam int TB_W               = 4;
   localparam int HASH_W             = 32;

   localparam logic [TB_W-1:0]   RESET_TABLE_BITS = 4'd10;
   localparam logic [HASH_W-1:0] HASH_MULT        = 32'h9e37_0001;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_LOOKUP = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_SLOT,
      ST_KEY,
      ST_WIPE,
      ST_OUT
   } state_type;

endpackage

// ----- rtl/linear_probe_hash_index.sv -----
// Open-addressed hash index with linear probing. Keys (64 bit) map to a home
// slot by XOR-folding the halves, multiplying by 0x9e370001 mod 2^32 and
// keeping the top table_bits bits. Slot state lives in one synchronous RAM
// (2^MAX_TABLE_BITS x 11) and keys in a second RAM (1024 x 64) indexed by
// position. One item is processed at a time. An insert hashes the key,
// reads a slot and checks it, and goes back to the read for each occupied
// slot passed over, until it finds an empty slot or the last active slot. A
// lookup takes the same steps and also compares the stored key of each
// occupied slot, stopping on an empty slot, a hit or the last active slot.
// Each probe is one slot-RAM read, and a lookup adds one key-RAM read per
// occupied slot. A clear sweeps every slot-RAM entry, one entry a cycle. After
// reset the same sweep runs before the first item is taken; table_bits writes
// are accepted throughout. A finished result sits in an output register, so
// the next item may be taken while it waits.
module linear_probe_hash_index
   import lphi_pkg::*;
#(
   parameter int MAX_TABLE_BITS = DEF_MAX_TABLE_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [POS_W-1:0]    req_position,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [POS_W-1:0]    rsp_found_position,
   input  logic                csr_wr_en,
   input  logic [TB_W-1:0]     csr_wr_data
);

   localparam int SLOT_DEPTH = 1 << MAX_TABLE_BITS;
   localparam int BITS_W     = $clog2(MAX_TABLE_BITS + 1);
   localparam int SA_W       = MAX_TABLE_BITS;

   logic [SLOT_W-1:0] slot_mem [SLOT_DEPTH];
   logic [KEY_W-1:0]  key_mem  [KEY_DEPTH];

   state_type           state_ff, state_in;
   logic [TB_W-1:0]     table_bits_ff;
   logic [SA_W-1:0]     slot_ff, slot_in;
   logic [SA_W:0]       count_ff, count_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   func_type            func_ff, func_in;
   logic [BITS_W-1:0]   bits_ff, bits_in;
   logic [HASH_W-1:0]   mixed_ff, mixed_in;
   status_type          res_status_ff, res_status_in;
   logic [POS_W-1:0]    res_found_ff, res_found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]    rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0]   slot_rd_ff;
   logic [KEY_W-1:0]    key_rd_ff;
   logic [POS_W-1:0]    idx_ff;

   logic                slot_we, slot_re, key_we, key_re;
   logic [SLOT_W-1:0]   slot_wdata;
   logic [SLOT_W-1:0]   slot_dec;
   logic [POS_W-1:0]    key_raddr;
   logic [HASH_W-1:0]   folded;
   logic [HASH_W-1:0]   home_full;
   logic [5:0]          shamt;
   logic [BITS_W-1:0]   act_bits;
   logic [SA_W:0]       span;
   logic [SA_W:0]       span_m1;
   logic [SA_W-1:0]     slot_next;
   logic                accept, out_free, slot_empty, key_hit, last_probe, wipe_last;

   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign slot_empty = (slot_rd_ff == '0);
   assign key_hit    = (key_rd_ff == key_ff);
   assign span       = {{SA_W{1'b0}}, 1'b1} << bits_ff;
   assign span_m1    = span - 1'b1;
   assign last_probe = ((count_ff + 1'b1) == span);
   assign wipe_last  = &slot_ff;
   assign slot_next  = (slot_ff + 1'b1) & span_m1[SA_W-1:0];
   assign slot_dec   = slot_rd_ff - 1'b1;
   assign key_raddr  = slot_dec[POS_W-1:0];
   assign folded     = req_key[HASH_W-1:0] ^ req_key[KEY_W-1:HASH_W];
   assign mixed_in   = folded * HASH_MULT;
   assign shamt      = 6'(HASH_W) - 6'(bits_ff);
   assign home_full  = mixed_ff >> shamt;

   always_comb begin
      if (table_bits_ff == '0) begin
         act_bits = BITS_W'(1);
      end else if (int'(table_bits_ff) > MAX_TABLE_BITS) begin
         act_bits = BITS_W'(MAX_TABLE_BITS);
      end else begin
         act_bits = BITS_W'(table_bits_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (wipe_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (func_type'(req_func))
                  FUNC_INSERT, FUNC_LOOKUP: state_in = ST_HASH;
                  FUNC_CLEAR:               state_in = ST_WIPE;
                  default:                  state_in = ST_OUT;
               endcase
            end
         end
         ST_HASH:  state_in = ST_PROBE;
         ST_PROBE: state_in = ST_SLOT;
         ST_SLOT: begin
            if (func_ff == FUNC_INSERT) begin
               if (slot_empty || last_probe) state_in = ST_OUT;
               else state_in = ST_PROBE;
            end else begin
               if (slot_empty) state_in = ST_OUT;
               else state_in = ST_KEY;
            end
         end
         ST_KEY: begin
            if (key_hit || last_probe) state_in = ST_OUT;
            else state_in = ST_PROBE;
         end
         ST_WIPE: begin
            if (wipe_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      req_ready     = 1'b0;
      slot_we       = 1'b0;
      slot_re       = 1'b0;
      key_we        = 1'b0;
      key_re        = 1'b0;
      slot_wdata    = '0;
      slot_in       = slot_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      func_in       = func_ff;
      bits_in       = bits_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      case (state_ff)
         ST_INIT: begin
            slot_we = 1'b1;
            slot_in = slot_ff + 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               key_in        = req_key;
               pos_in        = req_position;
               func_in       = func_type'(req_func);
               bits_in       = act_bits;
               slot_in       = '0;
               res_status_in = STATUS_OK;
               res_found_in  = '0;
            end
         end
         ST_HASH: begin
            slot_in  = home_full[SA_W-1:0];
            count_in = '0;
         end
         ST_PROBE: begin
            slot_re = 1'b1;
         end
         ST_SLOT: begin
            if (func_ff == FUNC_INSERT) begin
               if (slot_empty) begin
                  slot_we       = 1'b1;
                  slot_wdata    = {1'b0, pos_ff} + SLOT_W'(1);
                  key_we        = 1'b1;
                  res_status_in = STATUS_OK;
               end else if (last_probe) begin
                  res_status_in = STATUS_FULL;
               end else begin
                  slot_in  = slot_next;
                  count_in = count_ff + 1'b1;
               end
            end else begin
               if (slot_empty) res_status_in = STATUS_MISS;
               else key_re = 1'b1;
            end
         end
         ST_KEY: begin
            if (key_hit) begin
               res_status_in = STATUS_OK;
               res_found_in  = idx_ff;
            end else if (last_probe) begin
               res_status_in = STATUS_MISS;
            end else begin
               slot_in  = slot_next;
               count_in = count_ff + 1'b1;
            end
         end
         ST_WIPE: begin
            slot_we = 1'b1;
            slot_in = slot_ff + 1'b1;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         table_bits_ff <= RESET_TABLE_BITS;
         slot_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) table_bits_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      func_ff       <= func_in;
      bits_ff       <= bits_in;
      mixed_ff      <= mixed_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_ff] <= slot_wdata;
      if (slot_re) slot_rd_ff <= slot_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[pos_ff] <= key_ff;
      if (key_re) begin
         key_rd_ff <= key_mem[key_raddr];
         idx_ff    <= key_raddr;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;

   a_probe_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE || state_ff == ST_SLOT || state_ff == ST_KEY)
         |-> (count_ff < span) && ({1'b0, slot_ff} < span))
      else $error("probe walked outside the active slot range");

   a_insert_only_empty: assert property (@(posedge clock) disable iff (reset)
      (slot_we && state_ff == ST_SLOT) |-> slot_empty && func_ff == FUNC_INSERT)
      else $error("insert overwrote an occupied slot");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result loaded outside the output state");

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HASH || state_ff == ST_PROBE || state_ff == ST_SLOT)
         |-> bits_ff != '0 && int'(bits_ff) <= MAX_TABLE_BITS)
      else $error("active table bits out of range");

   a_no_write_on_lookup: assert property (@(posedge clock) disable iff (reset)
      key_we |-> state_ff == ST_SLOT && slot_we)
      else $error("key store written without a slot claim");

endmodule
